>>> rtl/core/gidl_pkg.sv
// Shared types and constants for the gate switch debounce and limit check block.
`timescale 1ns / 1ps

package gidl_pkg;

    // channel positions in masks and state
    localparam int CH_STOP   = 0;
    localparam int CH_OBST   = 1;
    localparam int CH_OPEN   = 2;
    localparam int CH_CLOSE  = 3;
    localparam int CH_BUTTON = 4;
    localparam int NUM_CH    = 5;

    // field and register widths
    localparam int HOLD_W     = 16;
    localparam int CONF_AGE_W = 8;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LIM_EN_W   = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INVERT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIM_EN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_HOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_HOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OBST_HOLD  = 3'd5;

    // limit enable bits
    localparam int LIM_EN_ALL   = 0;
    localparam int LIM_EN_OPEN  = 1;
    localparam int LIM_EN_CLOSE = 2;

    // result word bit positions
    localparam int OB_STOP_PRESSED   = 0;
    localparam int OB_OBST_CHANGED   = 1;
    localparam int OB_OBST_LEVEL     = 2;
    localparam int OB_OPEN_RISING    = 3;
    localparam int OB_CLOSE_RISING   = 4;
    localparam int OB_CONFLICT       = 5;
    localparam int OB_CONFLICT_EDGE  = 6;
    localparam int OB_BUTTON_PRESSED = 7;
    localparam int OB_STOP_LEVEL     = 8;
    localparam int OB_BUTTON_LEVEL   = 9;
    localparam int OB_OPEN_LEVEL     = 10;
    localparam int OB_CLOSE_LEVEL    = 11;

    // per-channel control from the top level
    typedef struct packed {
        logic step;
        logic first;
        logic active;
        logic level;
    } chan_ctrl_t;

    // per-channel status back to the top level
    typedef struct packed {
        logic stable;
        logic chg;
    } chan_stat_t;

    // conflict detector status
    typedef struct packed {
        logic conflict;
        logic conf_edge;
    } conf_stat_t;

endpackage

>>> rtl/core/gidl_chan.sv
// One debounce channel: last sampled level, stable level and saturating age counter.
`timescale 1ns / 1ps

module gidl_chan #(
    parameter int AGE_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  gidl_pkg::chan_ctrl_t        ctrl,
    input  logic [gidl_pkg::HOLD_W-1:0] hold,
    output gidl_pkg::chan_stat_t        stat
);

    localparam int CMP_W = (AGE_BITS > gidl_pkg::HOLD_W) ? AGE_BITS : gidl_pkg::HOLD_W;

    logic                last_reg, last_next;
    logic                stable_reg, stable_next;
    logic [AGE_BITS-1:0] age_reg, age_next;
    logic [AGE_BITS-1:0] age_upd;
    logic                hold_met;
    logic                chg;

    // age restarts on a change of the sampled level, else counts up and saturates
    always_comb begin
        if (ctrl.level != last_reg) begin
            age_upd = '0;
        end else if (age_reg != '1) begin
            age_upd = age_reg + AGE_BITS'(1);
        end else begin
            age_upd = age_reg;
        end
        hold_met = CMP_W'(age_upd) >= CMP_W'(hold);
        chg = ctrl.active && !ctrl.first && (stable_reg != ctrl.level) && hold_met;
    end

    // next state: first word loads, inactive channel stays frozen
    always_comb begin
        last_next   = last_reg;
        stable_next = stable_reg;
        age_next    = age_reg;
        if (ctrl.first) begin
            last_next   = ctrl.level;
            stable_next = ctrl.level;
            age_next    = '0;
        end else if (ctrl.active) begin
            last_next   = ctrl.level;
            age_next    = age_upd;
            if (chg) begin
                stable_next = ctrl.level;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg   <= 1'b0;
            stable_reg <= 1'b0;
            age_reg    <= '0;
        end else if (ctrl.step) begin
            last_reg   <= last_next;
            stable_reg <= stable_next;
            age_reg    <= age_next;
        end
    end

    assign stat.stable = stable_next;
    assign stat.chg    = chg;

endmodule

>>> rtl/core/gidl_conflict.sv
// Limit conflict timer: both limits active long enough raises a conflict and its edge.
`timescale 1ns / 1ps

module gidl_conflict #(
    parameter int CONFLICT_HOLD_MS = 200
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 open_act,
    input  logic                 close_act,
    output gidl_pkg::conf_stat_t stat
);

    localparam int AW = gidl_pkg::CONF_AGE_W;

    logic          timing_reg, timing_next;
    logic [AW-1:0] age_reg, age_next;
    logic          latched_reg, latched_next;
    logic          conflict;

    // timer runs while both limits read active, clears otherwise
    always_comb begin
        timing_next  = 1'b0;
        age_next     = '0;
        latched_next = 1'b0;
        conflict     = 1'b0;
        if (open_act && close_act) begin
            timing_next = 1'b1;
            if (!timing_reg) begin
                age_next = '0;
            end else if (age_reg != '1) begin
                age_next = age_reg + AW'(1);
            end else begin
                age_next = age_reg;
            end
            conflict     = age_next >= AW'(CONFLICT_HOLD_MS);
            latched_next = latched_reg || conflict;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg  <= 1'b0;
            age_reg     <= '0;
            latched_reg <= 1'b0;
        end else if (step) begin
            timing_reg  <= timing_next;
            age_reg     <= age_next;
            latched_reg <= latched_next;
        end
    end

    assign stat.conflict  = conflict;
    assign stat.conf_edge = conflict && !latched_reg;

endmodule

>>> rtl/core/gate_input_debounce_and_limit_check.sv
// An accepted s_ word is taken into the input register, then into the result register that drives
// m_ once that register is free or m_tready takes its word. Throughput: one word per cycle unless
// m_tready stalls; the debounce and conflict state update in one pass per word.
// A stalled result is held in the result register while one more word waits in the input register.
// Reset (aresetn low, synchronous) empties both registers, clears all debounce and conflict
// state and returns the configuration to its defaults; the first word after reset only
// loads the stable levels and raises no events.
`timescale 1ns / 1ps

module gate_input_debounce_and_limit_check #(
    parameter int CONFLICT_HOLD_MS = 200,
    parameter int STOP_HOLD_MS     = 30,
    parameter int BUTTON_HOLD_MS   = 50,
    parameter int AGE_BITS         = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // stop_raw, obstacle_raw, open_raw, close_raw, button_raw, 3 bits zero
    input  logic [gidl_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // stop_pressed, obstacle_changed, obstacle_level, open_rising, close_rising,
    // limits_conflict, limits_conflict_edge, button_pressed, stop_level,
    // button_level, open_level, close_level, 4 bits zero
    output logic [gidl_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_wr_en,
    input  logic [gidl_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [gidl_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int NCH = gidl_pkg::NUM_CH;
    localparam int HW  = gidl_pkg::HOLD_W;

    // configuration registers
    logic [NCH-1:0]                invert_reg;
    logic [NCH-1:0]                present_reg;
    logic [gidl_pkg::LIM_EN_W-1:0] lim_en_reg;
    logic [HW-1:0]                 open_hold_reg;
    logic [HW-1:0]                 close_hold_reg;
    logic [HW-1:0]                 obst_hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg     <= '0;
            present_reg    <= '1;
            lim_en_reg     <= '0;
            open_hold_reg  <= HW'(50);
            close_hold_reg <= HW'(50);
            obst_hold_reg  <= HW'(50);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                gidl_pkg::REG_INVERT:     invert_reg     <= cfg_wr_data[NCH-1:0];
                gidl_pkg::REG_PRESENT:    present_reg    <= cfg_wr_data[NCH-1:0];
                gidl_pkg::REG_LIM_EN:     lim_en_reg     <= cfg_wr_data[gidl_pkg::LIM_EN_W-1:0];
                gidl_pkg::REG_OPEN_HOLD:  open_hold_reg  <= cfg_wr_data[HW-1:0];
                gidl_pkg::REG_CLOSE_HOLD: close_hold_reg <= cfg_wr_data[HW-1:0];
                gidl_pkg::REG_OBST_HOLD:  obst_hold_reg  <= cfg_wr_data[HW-1:0];
                default: ;
            endcase
        end
    end

    // pipeline handshake
    logic           in_vld_reg, in_vld_next;
    logic [NCH-1:0] in_raw_reg;
    logic           out_vld_reg, out_vld_next;
    logic [gidl_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;
    logic           s_accept;
    logic           advance;
    logic           primed_reg;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_vld_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        out_vld_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            primed_reg  <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance) begin
                primed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_raw_reg <= s_tdata[NCH-1:0];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // sampled levels and channel activity
    logic [NCH-1:0] lvl;
    logic [NCH-1:0] active;
    logic           open_en, close_en;
    logic [HW-1:0]  hold [NCH];

    assign lvl      = (in_raw_reg ^ invert_reg) & present_reg;
    assign open_en  = lim_en_reg[gidl_pkg::LIM_EN_ALL] && lim_en_reg[gidl_pkg::LIM_EN_OPEN];
    assign close_en = lim_en_reg[gidl_pkg::LIM_EN_ALL] && lim_en_reg[gidl_pkg::LIM_EN_CLOSE];

    always_comb begin
        active = present_reg;
        active[gidl_pkg::CH_OPEN]  = present_reg[gidl_pkg::CH_OPEN] && open_en;
        active[gidl_pkg::CH_CLOSE] = present_reg[gidl_pkg::CH_CLOSE] && close_en;
    end

    assign hold[gidl_pkg::CH_STOP]   = HW'(STOP_HOLD_MS);
    assign hold[gidl_pkg::CH_OBST]   = obst_hold_reg;
    assign hold[gidl_pkg::CH_OPEN]   = open_hold_reg;
    assign hold[gidl_pkg::CH_CLOSE]  = close_hold_reg;
    assign hold[gidl_pkg::CH_BUTTON] = HW'(BUTTON_HOLD_MS);

    // debounce channels
    gidl_pkg::chan_ctrl_t ctrl [NCH];
    gidl_pkg::chan_stat_t stat [NCH];
    logic [NCH-1:0]       stable;
    logic [NCH-1:0]       chg;

    for (genvar i = 0; i < NCH; i++) begin : g_chan
        assign ctrl[i].step   = advance;
        assign ctrl[i].first  = !primed_reg;
        assign ctrl[i].active = active[i];
        assign ctrl[i].level  = lvl[i];

        gidl_chan #(
            .AGE_BITS(AGE_BITS)
        ) u_chan (
            .aclk   (aclk),
            .aresetn(aresetn),
            .ctrl   (ctrl[i]),
            .hold   (hold[i]),
            .stat   (stat[i])
        );

        assign stable[i] = stat[i].stable;
        assign chg[i]    = stat[i].chg;
    end

    // visible levels and conflict detector
    logic [NCH-1:0]       vis;
    logic                 open_act, close_act;
    gidl_pkg::conf_stat_t conf;

    assign vis       = stable & present_reg;
    assign open_act  = open_en && vis[gidl_pkg::CH_OPEN];
    assign close_act = close_en && vis[gidl_pkg::CH_CLOSE];

    gidl_conflict #(
        .CONFLICT_HOLD_MS(CONFLICT_HOLD_MS)
    ) u_conflict (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .open_act (open_act),
        .close_act(close_act),
        .stat     (conf)
    );

    // result word
    always_comb begin
        out_data_next = '0;
        out_data_next[gidl_pkg::OB_STOP_PRESSED] =
            chg[gidl_pkg::CH_STOP] && vis[gidl_pkg::CH_STOP];
        out_data_next[gidl_pkg::OB_OBST_CHANGED]  = chg[gidl_pkg::CH_OBST];
        out_data_next[gidl_pkg::OB_OBST_LEVEL]    = vis[gidl_pkg::CH_OBST];
        out_data_next[gidl_pkg::OB_OPEN_RISING]   = chg[gidl_pkg::CH_OPEN] && open_act;
        out_data_next[gidl_pkg::OB_CLOSE_RISING]  = chg[gidl_pkg::CH_CLOSE] && close_act;
        out_data_next[gidl_pkg::OB_CONFLICT]      = conf.conflict;
        out_data_next[gidl_pkg::OB_CONFLICT_EDGE] = conf.conf_edge;
        out_data_next[gidl_pkg::OB_BUTTON_PRESSED] =
            chg[gidl_pkg::CH_BUTTON] && vis[gidl_pkg::CH_BUTTON];
        out_data_next[gidl_pkg::OB_STOP_LEVEL]    = vis[gidl_pkg::CH_STOP];
        out_data_next[gidl_pkg::OB_BUTTON_LEVEL]  = vis[gidl_pkg::CH_BUTTON];
        out_data_next[gidl_pkg::OB_OPEN_LEVEL]    = open_act;
        out_data_next[gidl_pkg::OB_CLOSE_LEVEL]   = close_act;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> rtl/core/gidl_checker.sv
// Port-level checks for the gate switch debounce block, bound to the top level.
`timescale 1ns / 1ps

module gidl_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic [gidl_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // conflict edge only comes with the conflict flag
    a_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[gidl_pkg::OB_CONFLICT_EDGE] |-> m_tdata[gidl_pkg::OB_CONFLICT])
        else $error("conflict edge without conflict");

    // a conflict needs both limit levels active
    a_conflict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[gidl_pkg::OB_CONFLICT]
        |-> m_tdata[gidl_pkg::OB_OPEN_LEVEL] && m_tdata[gidl_pkg::OB_CLOSE_LEVEL])
        else $error("conflict without both limits active");

    // a rising limit event shows its level
    a_rising: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[gidl_pkg::OB_OPEN_RISING] || m_tdata[gidl_pkg::OB_CLOSE_RISING])
        |-> (!m_tdata[gidl_pkg::OB_OPEN_RISING] || m_tdata[gidl_pkg::OB_OPEN_LEVEL])
            && (!m_tdata[gidl_pkg::OB_CLOSE_RISING] || m_tdata[gidl_pkg::OB_CLOSE_LEVEL]))
        else $error("limit rising without its level");

endmodule

bind gate_input_debounce_and_limit_check gidl_checker u_gidl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tdata (m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
);

>>> bench/tb_top.sv
// Testbench for the gate switch debouncer with limit conflict detection.
`timescale 1ns / 1ps

module tb_top;
    import gidl_pkg::*;

    // block parameters, passed to the instance so the predictor uses the same values
    localparam int CONFLICT_HOLD_TICKS = 200;
    localparam int STOP_HOLD_TICKS     = 30;
    localparam int BUTTON_HOLD_TICKS   = 50;
    localparam int AGE_W               = 16;
    localparam int LIMIT_CYCLES        = 200000;
    localparam int SETTLE_CYCLES       = 6;
    localparam int HOLD_OFF_CYCLES     = 90;

    // result word fields, highest bit first
    typedef struct packed {
        logic close_level;
        logic open_level;
        logic button_level;
        logic stop_level;
        logic button_pressed;
        logic conflict_edge;
        logic conflict;
        logic close_rising;
        logic open_rising;
        logic obstacle_level;
        logic obstacle_changed;
        logic stop_pressed;
    } gate_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // stimulus control
    logic [NUM_CH-1:0] pending_ticks [$];
    gate_result_t      expected_results [$];
    logic              calm = 1'b0;
    logic              hold_off_req = 1'b0;
    logic              hold_off_done = 1'b0;
    int                hold_left = 0;
    int                mismatch_count = 0;
    int                result_index = 0;
    int                cycle_count = 0;

    // predictor configuration, same defaults as the block
    logic [NUM_CH-1:0]   inv_cfg = '0;
    logic [NUM_CH-1:0]   present_cfg = '1;
    logic [LIM_EN_W-1:0] lim_en_cfg = '0;
    logic [HOLD_W-1:0]   hold_open = 16'd50;
    logic [HOLD_W-1:0]   hold_close = 16'd50;
    logic [HOLD_W-1:0]   hold_obst = 16'd50;

    // predictor debounce and conflict state
    logic [NUM_CH-1:0]     last_lvl = '0;
    logic [NUM_CH-1:0]     stable_lvl = '0;
    logic [AGE_W-1:0]      chan_age [NUM_CH];
    logic                  primed = 1'b0;
    logic                  conf_timing = 1'b0;
    logic [CONF_AGE_W-1:0] conf_age = '0;
    logic                  conf_latched = 1'b0;

    logic [M_DATA_W-1:0] want_word, got_word;
    gate_result_t        want_res;

    gate_input_debounce_and_limit_check #(
        .CONFLICT_HOLD_MS (CONFLICT_HOLD_TICKS),
        .STOP_HOLD_MS     (STOP_HOLD_TICKS),
        .BUTTON_HOLD_MS   (BUTTON_HOLD_TICKS),
        .AGE_BITS         (AGE_W)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // one debounce tick: updates the predictor state, returns the expected word
    function automatic gate_result_t predict_tick(input logic [NUM_CH-1:0] raw);
        logic [NUM_CH-1:0] lvl;
        logic [NUM_CH-1:0] vis;
        logic [NUM_CH-1:0] chg;
        logic [HOLD_W-1:0] hold;
        logic              open_en, close_en, open_act, close_act;
        gate_result_t      res;
        res = '0;
        chg = '0;
        lvl = (raw ^ inv_cfg) & present_cfg;
        open_en = lim_en_cfg[LIM_EN_ALL] && lim_en_cfg[LIM_EN_OPEN];
        close_en = lim_en_cfg[LIM_EN_ALL] && lim_en_cfg[LIM_EN_CLOSE];
        if (!primed) begin
            // first tick loads the levels, no events
            last_lvl = lvl;
            stable_lvl = lvl;
            for (int ch = 0; ch < NUM_CH; ch++) chan_age[ch] = '0;
            primed = 1'b1;
        end else begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                // absent channels and disabled limits stay frozen
                if (present_cfg[ch] && !(ch == CH_OPEN && !open_en)
                        && !(ch == CH_CLOSE && !close_en)) begin
                    case (ch)
                        CH_STOP:  hold = HOLD_W'(STOP_HOLD_TICKS);
                        CH_OBST:  hold = hold_obst;
                        CH_OPEN:  hold = hold_open;
                        CH_CLOSE: hold = hold_close;
                        default:  hold = HOLD_W'(BUTTON_HOLD_TICKS);
                    endcase
                    if (lvl[ch] != last_lvl[ch]) begin
                        last_lvl[ch] = lvl[ch];
                        chan_age[ch] = '0;
                    end else if (chan_age[ch] != '1) begin
                        chan_age[ch] = chan_age[ch] + 1'b1;
                    end
                    if (stable_lvl[ch] != last_lvl[ch] && chan_age[ch] >= hold) begin
                        stable_lvl[ch] = last_lvl[ch];
                        chg[ch] = 1'b1;
                    end
                end
            end
        end

        vis = stable_lvl & present_cfg;
        open_act = open_en && vis[CH_OPEN];
        close_act = close_en && vis[CH_CLOSE];

        // conflict timer, cleared whenever either limit drops
        if (open_act && close_act) begin
            if (!conf_timing) begin
                conf_timing = 1'b1;
                conf_age = '0;
            end else if (conf_age != '1) begin
                conf_age = conf_age + 1'b1;
            end
            if (conf_age >= CONFLICT_HOLD_TICKS) begin
                res.conflict = 1'b1;
                res.conflict_edge = !conf_latched;
                conf_latched = 1'b1;
            end
        end else begin
            conf_timing = 1'b0;
            conf_age = '0;
            conf_latched = 1'b0;
        end

        res.stop_pressed = chg[CH_STOP] && vis[CH_STOP];
        res.obstacle_changed = chg[CH_OBST];
        res.obstacle_level = vis[CH_OBST];
        res.open_rising = chg[CH_OPEN] && open_act;
        res.close_rising = chg[CH_CLOSE] && close_act;
        res.button_pressed = chg[CH_BUTTON] && vis[CH_BUTTON];
        res.stop_level = vis[CH_STOP];
        res.button_level = vis[CH_BUTTON];
        res.open_level = open_act;
        res.close_level = close_act;
        return res;
    endfunction

    // driver: offers queued ticks, idles at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_ticks.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
                s_tdata <= {{(S_DATA_W - NUM_CH){1'b0}}, pending_ticks.pop_front()};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_off_req && !hold_off_done) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_OFF_CYCLES;
            hold_off_done <= 1'b1;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 7);
        end
    end

    // monitor: tracks config writes, predicts accepted words, checks results
    always @(posedge aclk) begin
        if (!aresetn) begin
            inv_cfg = '0;
            present_cfg = '1;
            lim_en_cfg = '0;
            hold_open = 16'd50;
            hold_close = 16'd50;
            hold_obst = 16'd50;
            last_lvl = '0;
            stable_lvl = '0;
            for (int ch = 0; ch < NUM_CH; ch++) chan_age[ch] = '0;
            primed = 1'b0;
            conf_timing = 1'b0;
            conf_age = '0;
            conf_latched = 1'b0;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_INVERT:     inv_cfg = cfg_wr_data[NUM_CH-1:0];
                    REG_PRESENT:    present_cfg = cfg_wr_data[NUM_CH-1:0];
                    REG_LIM_EN:     lim_en_cfg = cfg_wr_data[LIM_EN_W-1:0];
                    REG_OPEN_HOLD:  hold_open = cfg_wr_data[HOLD_W-1:0];
                    REG_CLOSE_HOLD: hold_close = cfg_wr_data[HOLD_W-1:0];
                    REG_OBST_HOLD:  hold_obst = cfg_wr_data[HOLD_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_tick(s_tdata[NUM_CH-1:0]));
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("word %0d: unexpected result %h", result_index, m_tdata);
                end else begin
                    want_res = expected_results.pop_front();
                    want_word = {{(M_DATA_W - 12){1'b0}}, want_res};
                    got_word = m_tdata;
                    for (int b = 0; b < M_DATA_W; b++) begin
                        if (want_word[b] !== got_word[b]) begin
                            mismatch_count++;
                            if (mismatch_count <= 10)
                                $display("word %0d bit %0d: expected %b actual %b (%h vs %h)",
                                         result_index, b, want_word[b], got_word[b],
                                         want_word, got_word);
                        end
                    end
                end
                result_index++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait until every queued tick is taken and every result is back
    task automatic drain();
        while (pending_ticks.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // switch activity: steady runs with bounces; bits in keep_mask are forced
    task automatic push_sequences(input int n_ticks, input logic [NUM_CH-1:0] keep_mask,
                                  input logic [NUM_CH-1:0] keep_val);
        logic [NUM_CH-1:0] target;
        logic [NUM_CH-1:0] word;
        int                run_len;
        target = NUM_CH'($urandom);
        while (n_ticks > 0) begin
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                 : $urandom_range(20, 70);
            target = target ^ NUM_CH'($urandom);
            for (int k = 0; k < run_len && n_ticks > 0; k++) begin
                word = target;
                // short glitch on one switch
                if ($urandom_range(0, 99) < 6)
                    word = word ^ (NUM_CH'(1) << $urandom_range(0, NUM_CH - 1));
                word = (word & ~keep_mask) | (keep_val & keep_mask);
                pending_ticks.push_back(word);
                n_ticks--;
            end
        end
    endtask

    initial begin
        logic [16*NUM_CH-1:0] probe;
        probe = {5'b11111, 5'b00000, 5'b00100, 5'b11011, 5'b01010, 5'b10101,
                 5'b00000, 5'b11111, 5'b11111, 5'b01100, 5'b00000, 5'b00010,
                 5'b00010, 5'b00000, 5'b00100, 5'b00000};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults: first tick loads all-high levels, limits disabled and frozen
        pending_ticks.push_back(5'b11111);
        pending_ticks.push_back(5'b00000);
        pending_ticks.push_back(5'b11111);
        pending_ticks.push_back(5'b00000);
        push_sequences(100, '0, '0);
        drain();

        // zero open, close and obstacle hold times, close limit absent
        write_reg(REG_INVERT, 16'd0);
        write_reg(REG_PRESENT, 16'b10111);
        write_reg(REG_LIM_EN, 16'b111);
        write_reg(REG_OPEN_HOLD, 16'd0);
        write_reg(REG_CLOSE_HOLD, 16'd0);
        write_reg(REG_OBST_HOLD, 16'd0);
        for (int i = 0; i < 16; i++) pending_ticks.push_back(probe[i*NUM_CH +: NUM_CH]);
        push_sequences(70, '0, '0);
        drain();

        // both limits held: conflict, its edge, age saturation, reset, conflict again
        write_reg(REG_PRESENT, 16'b11111);
        write_reg(REG_OPEN_HOLD, 16'd4);
        write_reg(REG_CLOSE_HOLD, 16'd2);
        write_reg(REG_OBST_HOLD, 16'd1);
        hold_off_req <= 1'b1;
        push_sequences(12, '0, '0);
        push_sequences(265, 5'b01100, 5'b01100);
        push_sequences(8, 5'b01100, 5'b00100);
        push_sequences(210, 5'b01100, 5'b01100);
        drain();

        // all inverted, some absent, close disabled, unreachable open hold
        write_reg(REG_INVERT, 16'b11111);
        write_reg(REG_PRESENT, 16'b01010);
        write_reg(REG_LIM_EN, 16'b011);
        write_reg(REG_OPEN_HOLD, 16'hFFFF);
        write_reg(REG_CLOSE_HOLD, 16'd1);
        write_reg(REG_OBST_HOLD, 16'd3);
        calm <= 1'b1;
        push_sequences(80, '0, '0);
        drain();
        calm <= 1'b0;

        // nothing wired, master limit enable off
        write_reg(REG_INVERT, 16'd0);
        write_reg(REG_PRESENT, 16'd0);
        write_reg(REG_LIM_EN, 16'b110);
        push_sequences(30, '0, '0);
        drain();

        // random settings
        for (int p = 0; p < 2; p++) begin
            write_reg(REG_INVERT, 16'($urandom_range(0, 31)));
            write_reg(REG_PRESENT, 16'($urandom_range(0, 31)));
            write_reg(REG_LIM_EN, 16'($urandom_range(0, 7)));
            write_reg(REG_OPEN_HOLD, 16'($urandom_range(0, 12)));
            write_reg(REG_CLOSE_HOLD, 16'($urandom_range(0, 12)));
            write_reg(REG_OBST_HOLD, 16'($urandom_range(0, 12)));
            push_sequences(60, '0, '0);
            drain();
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
